>>> rtl/dlf_pkg.sv
`default_nettype none
package dlf_pkg;

    // layer sizing
    localparam int IN_MAX       = 64;
    localparam int OUT_MAX      = 64;
    localparam int INDEX_SPAN   = 64;
    localparam int IN_USE_MAX   = (IN_MAX < INDEX_SPAN) ? IN_MAX : INDEX_SPAN;
    localparam int WEIGHT_DEPTH = IN_MAX * OUT_MAX;

    // address and counter widths
    localparam int W_IADDR = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int W_OADDR = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
    localparam int W_WADDR = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
    localparam int W_ICNT  = W_IADDR + 1;
    localparam int W_OCNT  = W_OADDR + 1;

    // field widths
    localparam int MODE_W    = 2;
    localparam int INDEX_W   = 6;
    localparam int DATA_W    = 16;
    localparam int COUNT_W   = 7;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = 48;
    localparam int RES_W     = 32;
    localparam int FRAC_BITS = 12;

    // config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_BIAS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_VALUE = 3'd4;

    // command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [MODE_W-1:0] {
        OP_WR_WEIGHT = 2'd0,
        OP_WR_ACT    = 2'd1,
        OP_COMPUTE   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_eng_state;

    typedef struct packed {
        t_op                op;
        logic [INDEX_W-1:0] in_idx;
        logic [INDEX_W-1:0] out_idx;
        logic [DATA_W-1:0]  data;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    typedef struct packed {
        logic [COUNT_W-1:0]       in_count;
        logic [COUNT_W-1:0]       out_count;
        logic                     act_mode;
        logic                     has_bias;
        logic signed [DATA_W-1:0] bias_value;
    } t_cfg;

endpackage
`default_nettype wire

>>> rtl/dense_layer_forward.sv
// Dense layer forward pass, fixed point Q4.12 in, Q20.12 out.
// Input channel (i_in_valid / o_in_stall): mode 0 writes a weight at
// (in_index, out_index), mode 1 writes an activation at in_index, mode 2
// starts a compute; mode 3 and out-of-range indexes are dropped.
// Output channel (o_out_valid / i_out_stall): one transaction per output
// neuron, in order from 0, with the saturated sum, its activation and a
// last flag on the final neuron.
// Config port (i_cfg_we, i_cfg_index, i_cfg_data) sets in_count, out_count,
// act_mode, has_bias and bias_value; write it only while the block is idle.
// Transactions land in a four-entry command queue; the engine drains it in
// order, doing each memory write as it takes it. A compute runs each neuron
// with one multiply-accumulate per cycle through the single read port of the
// weight memory, then a pipeline drain and the output load.
// Reset empties the queue, idles the engine, drops the output valid and restores the
// config defaults; weight and activation memories are not cleared.
// While the receiver stalls, the result holds; the engine waits with the next
// one ready and the queue keeps taking transactions until it fills.
`default_nettype none
module dense_layer_forward import dlf_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [MODE_W-1:0]         i_mode,
    input  wire logic [INDEX_W-1:0]        i_in_index,
    input  wire logic [INDEX_W-1:0]        i_out_index,
    input  wire logic signed [DATA_W-1:0]  i_data_value,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [INDEX_W-1:0]             o_neuron_index,
    output logic signed [RES_W-1:0]        o_pre_sum,
    output logic signed [RES_W-1:0]        o_out_value,
    output logic                           o_last
);

    t_cfg    r_cfg;
    t_q_head head;
    logic    pop;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_count   <= COUNT_W'(1);
            r_cfg.out_count  <= COUNT_W'(1);
            r_cfg.act_mode   <= 1'b0;
            r_cfg.has_bias   <= 1'b0;
            r_cfg.bias_value <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IN_COUNT:   r_cfg.in_count   <= i_cfg_data[COUNT_W-1:0];
                CFG_OUT_COUNT:  r_cfg.out_count  <= i_cfg_data[COUNT_W-1:0];
                CFG_ACT_MODE:   r_cfg.act_mode   <= i_cfg_data[0];
                CFG_HAS_BIAS:   r_cfg.has_bias   <= i_cfg_data[0];
                CFG_BIAS_VALUE: r_cfg.bias_value <= $signed(i_cfg_data[DATA_W-1:0]);
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    dlf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_in_index  (i_in_index),
        .i_out_index (i_out_index),
        .i_data_value(i_data_value),
        .o_head      (head),
        .i_pop       (pop)
    );

    dlf_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_neuron_index(o_neuron_index),
        .o_pre_sum     (o_pre_sum),
        .o_out_value   (o_out_value),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire

>>> rtl/dlf_ram.sv
`default_nettype none
module dlf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/dlf_front.sv
`default_nettype none
module dlf_front import dlf_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [MODE_W-1:0]         i_mode,
    input  wire logic [INDEX_W-1:0]        i_in_index,
    input  wire logic [INDEX_W-1:0]        i_out_index,
    input  wire logic signed [DATA_W-1:0]  i_data_value,
    output t_q_head                        o_head,
    input  wire logic                      i_pop
);

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              full;
    logic              keep;
    logic              push;
    t_cmd              cmd;

    assign full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_in_stall = full;

    // classify: drop unused mode and out-of-range indexes
    always_comb begin
        keep = 1'b0;
        cmd  = '{op: OP_COMPUTE, in_idx: i_in_index, out_idx: i_out_index,
                 data: i_data_value};
        case (i_mode)
            OP_WR_WEIGHT: begin
                cmd.op = OP_WR_WEIGHT;
                keep   = (32'(i_in_index) < IN_MAX) && (32'(i_out_index) < OUT_MAX);
            end
            OP_WR_ACT: begin
                cmd.op = OP_WR_ACT;
                keep   = (32'(i_in_index) < IN_MAX);
            end
            OP_COMPUTE: begin
                cmd.op = OP_COMPUTE;
                keep   = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign push = i_in_valid && !full && keep;

    // queue pointers
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        case ({push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage, no reset
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_q[r_rd_ptr];

endmodule
`default_nettype wire

>>> rtl/dlf_engine.sv
`default_nettype none
module dlf_engine import dlf_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire t_q_head                i_head,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [INDEX_W-1:0]          o_neuron_index,
    output logic signed [RES_W-1:0]     o_pre_sum,
    output logic signed [RES_W-1:0]     o_out_value,
    output logic                        o_last
);

    localparam logic signed [ACC_W-1:0] SAT_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -48'sh0000_8000_0000;

    t_eng_state                r_state, n_state;
    logic [W_ICNT-1:0]         r_icnt, n_icnt;
    logic [W_OADDR-1:0]        r_ocnt, n_ocnt;
    logic                      r_v1, n_v1;
    logic                      r_v2, n_v2;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic                      r_out_valid, n_out_valid;
    logic [INDEX_W-1:0]        r_out_idx, n_out_idx;
    logic signed [RES_W-1:0]   r_out_pre, n_out_pre;
    logic signed [RES_W-1:0]   r_out_act, n_out_act;
    logic                      r_out_last, n_out_last;

    logic [W_ICNT-1:0]         n_in;
    logic [W_OCNT-1:0]         n_out;
    logic signed [ACC_W-1:0]   acc_init;
    logic signed [ACC_W-1:0]   shifted;
    logic signed [RES_W-1:0]   pre;
    logic                      issue;
    logic                      slot_free;
    logic                      is_last;

    logic                      wt_we, act_we;
    logic [W_WADDR-1:0]        wt_waddr, wt_raddr;
    logic [W_IADDR-1:0]        act_waddr, act_raddr;
    logic [DATA_W-1:0]         wt_rdata, act_rdata;

    // memories
    dlf_ram #(.WIDTH(DATA_W), .DEPTH(WEIGHT_DEPTH)) u_wt_ram (
        .i_clk  (i_clk),
        .i_we   (wt_we),
        .i_waddr(wt_waddr),
        .i_wdata(i_head.cmd.data),
        .i_raddr(wt_raddr),
        .o_rdata(wt_rdata)
    );

    dlf_ram #(.WIDTH(DATA_W), .DEPTH(IN_MAX)) u_act_ram (
        .i_clk  (i_clk),
        .i_we   (act_we),
        .i_waddr(act_waddr),
        .i_wdata(i_head.cmd.data),
        .i_raddr(act_raddr),
        .o_rdata(act_rdata)
    );

    // clipped counts
    assign n_in  = (32'(i_cfg.in_count) > IN_USE_MAX) ? W_ICNT'(IN_USE_MAX)
                                                      : W_ICNT'(i_cfg.in_count);
    assign n_out = (32'(i_cfg.out_count) > OUT_MAX) ? W_OCNT'(OUT_MAX)
                                                    : W_OCNT'(i_cfg.out_count);

    // bias enters the accumulator at Q24.24
    assign acc_init = i_cfg.has_bias
        ? ({{(ACC_W-DATA_W){i_cfg.bias_value[DATA_W-1]}}, i_cfg.bias_value} <<< FRAC_BITS)
        : '0;

    // memory addresses
    assign wt_waddr  = W_WADDR'(W_WADDR'(W_IADDR'(i_head.cmd.in_idx)) * W_WADDR'(OUT_MAX)
                                + W_WADDR'(i_head.cmd.out_idx));
    assign act_waddr = W_IADDR'(i_head.cmd.in_idx);
    assign act_raddr = r_icnt[W_IADDR-1:0];
    assign wt_raddr  = W_WADDR'(W_WADDR'(act_raddr) * W_WADDR'(OUT_MAX) + W_WADDR'(r_ocnt));

    // floor to Q20.12 and saturate
    assign shifted = r_acc >>> FRAC_BITS;
    always_comb begin
        if (shifted > SAT_MAX) begin
            pre = SAT_MAX[RES_W-1:0];
        end else if (shifted < SAT_MIN) begin
            pre = SAT_MIN[RES_W-1:0];
        end else begin
            pre = shifted[RES_W-1:0];
        end
    end

    assign issue     = (r_icnt < n_in);
    assign slot_free = !r_out_valid || !i_out_stall;
    assign is_last   = ((W_OCNT'(r_ocnt) + 1'b1) == n_out);

    // sequencer: next state and datapath controls
    always_comb begin
        n_state     = r_state;
        n_icnt      = r_icnt;
        n_ocnt      = r_ocnt;
        n_v1        = 1'b0;
        n_v2        = r_v1;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_idx   = r_out_idx;
        n_out_pre   = r_out_pre;
        n_out_act   = r_out_act;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        wt_we       = 1'b0;
        act_we      = 1'b0;

        if (r_v1) begin
            n_prod = $signed(act_rdata) * $signed(wt_rdata);
        end

        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    case (i_head.cmd.op)
                        OP_WR_WEIGHT: wt_we  = 1'b1;
                        OP_WR_ACT:    act_we = 1'b1;
                        OP_COMPUTE: begin
                            if (n_out != '0) begin
                                n_state = ST_RUN;
                                n_icnt  = '0;
                                n_ocnt  = '0;
                                n_acc   = acc_init;
                            end
                        end
                        default: o_pop = 1'b1;
                    endcase
                end
            end
            ST_RUN: begin
                // issue reads, multiply, accumulate
                if (issue) begin
                    n_v1   = 1'b1;
                    n_icnt = r_icnt + 1'b1;
                end
                if (r_v2) begin
                    n_acc = r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
                end
                if (!issue && !r_v1 && !r_v2) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = INDEX_W'(r_ocnt);
                    n_out_pre   = pre;
                    n_out_act   = (i_cfg.act_mode && pre[RES_W-1]) ? '0 : pre;
                    n_out_last  = is_last;
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_RUN;
                        n_ocnt  = r_ocnt + 1'b1;
                        n_icnt  = '0;
                        n_acc   = acc_init;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_icnt      <= '0;
            r_ocnt      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_icnt      <= n_icnt;
            r_ocnt      <= n_ocnt;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod     <= n_prod;
        r_acc      <= n_acc;
        r_out_idx  <= n_out_idx;
        r_out_pre  <= n_out_pre;
        r_out_act  <= n_out_act;
        r_out_last <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_neuron_index = r_out_idx;
    assign o_pre_sum      = r_out_pre;
    assign o_out_value    = r_out_act;
    assign o_last         = r_out_last;

endmodule
`default_nettype wire

>>> rtl/dlf_checker.sv
`default_nettype none
module dlf_checker import dlf_pkg::*; (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_stall,
    input wire logic [INDEX_W-1:0]       o_neuron_index,
    input wire logic signed [RES_W-1:0]  o_pre_sum,
    input wire logic signed [RES_W-1:0]  o_out_value,
    input wire logic                     o_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_neuron_index)
            && $stable(o_pre_sum) && $stable(o_out_value) && $stable(o_last))
        else $error("result changed while stalled");

    // activation is either the sum or zero
    a_act_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_value == o_pre_sum) || (o_out_value == '0))
        else $error("activation is neither the sum nor zero");

    // ReLU only clamps negative sums
    a_relu_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_value != o_pre_sum) |-> o_pre_sum[RES_W-1])
        else $error("non-negative sum was clamped");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind dense_layer_forward dlf_checker u_dlf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_neuron_index(o_neuron_index),
    .o_pre_sum     (o_pre_sum),
    .o_out_value   (o_out_value),
    .o_last        (o_last)
);
`default_nettype wire

>>> verif/dense_layer_forward_tb.sv
`default_nettype none
module dense_layer_forward_tb;
    import dlf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CLK_PERIOD   = 10;
    localparam int         RESET_CYCLES = 5;
    localparam int         DRAIN_CYCLES = 32;
    localparam int         ITEM_TARGET  = 360;
    localparam int         QUIET_TAIL   = 50;
    localparam longint     TIMEOUT_NS   = 64'd100_000_000;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam longint     SUM_MAX      = 64'sd2147483647;
    localparam longint     SUM_MIN      = -64'sd2147483648;

    typedef struct {
        logic [MODE_W-1:0]        mode;
        logic [INDEX_W-1:0]       in_idx;
        logic [INDEX_W-1:0]       out_idx;
        logic signed [DATA_W-1:0] data;
    } layer_item_t;

    typedef struct {
        logic [INDEX_W-1:0]      neuron_index;
        logic signed [RES_W-1:0] pre_sum;
        logic signed [RES_W-1:0] out_value;
        logic                    last;
    } neuron_result_t;

    // DUT ports
    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data     = '0;
    logic                      i_in_valid     = 1'b0;
    logic                      o_in_stall;
    logic [MODE_W-1:0]         i_mode         = '0;
    logic [INDEX_W-1:0]        i_in_index     = '0;
    logic [INDEX_W-1:0]        i_out_index    = '0;
    logic signed [DATA_W-1:0]  i_data_value   = '0;
    logic                      o_out_valid;
    logic                      i_out_stall    = 1'b0;
    logic [INDEX_W-1:0]        o_neuron_index;
    logic signed [RES_W-1:0]   o_pre_sum;
    logic signed [RES_W-1:0]   o_out_value;
    logic                      o_last;

    // predictor state: its own copy of both stores and the registers
    logic signed [DATA_W-1:0] weight_mem [IN_MAX][OUT_MAX];
    logic signed [DATA_W-1:0] act_mem [IN_MAX];
    t_cfg                     layer_cfg;
    neuron_result_t           expected_neurons [$];

    // stimulus side bookkeeping: which entries have been loaded so far
    bit          wt_loaded [IN_MAX][OUT_MAX];
    bit          act_loaded [IN_MAX];
    layer_item_t pending_items [$];

    bit drv_busy       = 1'b0;
    bit in_taken       = 1'b0;
    bit idle_on        = 1'b1;
    int in_burst_odds  = 0;
    int out_burst_odds = 0;
    int in_gap_left    = 0;
    int out_gap_left   = 0;

    int mismatch_count  = 0;
    int results_checked = 0;
    int computes_seen   = 0;
    int items_sent      = 0;
    int settings_used   = 0;

    dense_layer_forward uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_in_index     (i_in_index),
        .i_out_index    (i_out_index),
        .i_data_value   (i_data_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_neuron_index (o_neuron_index),
        .o_pre_sum      (o_pre_sum),
        .o_out_value    (o_out_value),
        .o_last         (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Layer predictor: loads update the stores, a compute queues one result per neuron
    function automatic void apply_layer_item(input logic [MODE_W-1:0] mode,
                                             input logic [INDEX_W-1:0] ii,
                                             input logic [INDEX_W-1:0] oi,
                                             input logic signed [DATA_W-1:0] data);
        int             n_in;
        int             n_out;
        longint         acc;
        longint         pre;
        neuron_result_t res;
        case (mode)
            OP_WR_WEIGHT: weight_mem[ii][oi] = data;
            OP_WR_ACT:    act_mem[ii] = data;
            OP_COMPUTE: begin
                computes_seen++;
                n_in  = (layer_cfg.in_count > IN_USE_MAX) ? IN_USE_MAX : layer_cfg.in_count;
                n_out = (layer_cfg.out_count > OUT_MAX) ? OUT_MAX : layer_cfg.out_count;
                for (int o = 0; o < n_out; o++) begin
                    acc = 0;
                    for (int i = 0; i < n_in; i++)
                        acc += longint'(act_mem[i]) * longint'(weight_mem[i][o]);
                    if (layer_cfg.has_bias)
                        acc += longint'($signed(layer_cfg.bias_value)) * 4096;
                    // Q40.24 -> Q20.12, floor, then clamp to 32 bits
                    pre = acc >>> FRAC_BITS;
                    if (pre > SUM_MAX)
                        pre = SUM_MAX;
                    else if (pre < SUM_MIN)
                        pre = SUM_MIN;
                    res.neuron_index = o[INDEX_W-1:0];
                    res.pre_sum      = pre[RES_W-1:0];
                    res.out_value    = (layer_cfg.act_mode && pre < 0) ? '0 : pre[RES_W-1:0];
                    res.last         = (o == n_out - 1);
                    expected_neurons = {expected_neurons, res};
                end
            end
            default: ;
        endcase
    endfunction

    // Monitor: check results, feed accepted input transactions to the predictor
    always @(posedge i_clk) begin : port_monitor
        neuron_result_t want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                if (expected_neurons.size() == 0) begin
                    $error("unexpected result: neuron_index %0d, pre_sum %0d",
                           o_neuron_index, o_pre_sum);
                    mismatch_count++;
                end else begin
                    want = expected_neurons.pop_front();
                    results_checked++;
                    if (o_neuron_index !== want.neuron_index) begin
                        $error("neuron_index: expected %0d, actual %0d",
                               want.neuron_index, o_neuron_index);
                        mismatch_count++;
                    end
                    if (o_pre_sum !== want.pre_sum) begin
                        $error("pre_sum: expected %0d, actual %0d", want.pre_sum, o_pre_sum);
                        mismatch_count++;
                    end
                    if (o_out_value !== want.out_value) begin
                        $error("out_value: expected %0d, actual %0d",
                               want.out_value, o_out_value);
                        mismatch_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, o_last);
                        mismatch_count++;
                    end
                end
            end
            in_taken <= i_in_valid && (o_in_stall === 1'b0);
            if (i_in_valid && o_in_stall === 1'b0)
                apply_layer_item(i_mode, i_in_index, i_out_index, i_data_value);
        end
    end

    // Driver: present queued items, hold each until taken, idle in random bursts
    always @(negedge i_clk) begin : item_driver
        layer_item_t cur;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (drv_busy && in_taken)
                drv_busy = 1'b0;
            if (!drv_busy) begin
                if (in_gap_left != 0) begin
                    in_gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() != 0 && in_burst_odds != 0 &&
                             $urandom_range(1, in_burst_odds) == 1) begin
                    in_gap_left = $urandom_range(0, 18);
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    cur = pending_items.pop_front();
                    i_mode       <= cur.mode;
                    i_in_index   <= cur.in_idx;
                    i_out_index  <= cur.out_idx;
                    i_data_value <= cur.data;
                    i_in_valid   <= 1'b1;
                    drv_busy     = 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall bursts
    always @(negedge i_clk) begin
        if (!i_rst_n || out_burst_odds == 0) begin
            out_gap_left = 0;
            i_out_stall <= 1'b0;
        end else if (out_gap_left != 0) begin
            out_gap_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(1, out_burst_odds) == 1) begin
            out_gap_left = $urandom_range(0, 18);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_q412();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return DATA_W'($signed($urandom_range(0, 15)) - 8);
            default: return r[DATA_W-1:0];
        endcase
    endfunction

    function automatic logic [INDEX_W-1:0] rand_index();
        return INDEX_W'($urandom);
    endfunction

    function automatic int pick_burst_odds();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 2;
            2:       return 6;
            default: return 12;
        endcase
    endfunction

    function automatic void queue_item(input logic [MODE_W-1:0] mode,
                                       input logic [INDEX_W-1:0] ii,
                                       input logic [INDEX_W-1:0] oi,
                                       input logic signed [DATA_W-1:0] data);
        layer_item_t it;
        it.mode    = mode;
        it.in_idx  = ii;
        it.out_idx = oi;
        it.data    = data;
        pending_items = {pending_items, it};
        if (mode == OP_WR_WEIGHT)
            wt_loaded[ii][oi] = 1'b1;
        if (mode == OP_WR_ACT)
            act_loaded[ii] = 1'b1;
        if (mode != MODE_UNUSED)
            items_sent++;
    endfunction

    function automatic void push_compute();
        queue_item(OP_COMPUTE, rand_index(), rand_index(), rand_q412());
    endfunction

    // random loads anywhere in both stores
    function automatic void scatter_loads(input int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 1))
                queue_item(OP_WR_WEIGHT, rand_index(), rand_index(), rand_q412());
            else
                queue_item(OP_WR_ACT, rand_index(), rand_index(), rand_q412());
        end
    endfunction

    // load every entry the next compute reads that has never been written
    function automatic void load_missing(input int n_in, input int n_out);
        for (int i = 0; i < n_in; i++) begin
            if (!act_loaded[i])
                queue_item(OP_WR_ACT, INDEX_W'(i), rand_index(), rand_q412());
            for (int o = 0; o < n_out; o++)
                if (!wt_loaded[i][o])
                    queue_item(OP_WR_WEIGHT, INDEX_W'(i), INDEX_W'(o), rand_q412());
        end
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || drv_busy || expected_neurons.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_IN_COUNT:   layer_cfg.in_count   = val[COUNT_W-1:0];
            CFG_OUT_COUNT:  layer_cfg.out_count  = val[COUNT_W-1:0];
            CFG_ACT_MODE:   layer_cfg.act_mode   = val[0];
            CFG_HAS_BIAS:   layer_cfg.has_bias   = val[0];
            CFG_BIAS_VALUE: layer_cfg.bias_value = val[DATA_W-1:0];
            default: ;
        endcase
    endtask

    // new layer setting, only once the block has gone idle
    task automatic set_layer(input int in_cfg, input int out_cfg, input bit relu_on,
                             input bit bias_on, input logic signed [DATA_W-1:0] bias);
        wait_drained();
        cfg_write(CFG_IN_COUNT, CFG_DATA_W'(in_cfg));
        cfg_write(CFG_OUT_COUNT, CFG_DATA_W'(out_cfg));
        cfg_write(CFG_ACT_MODE, CFG_DATA_W'(relu_on));
        cfg_write(CFG_HAS_BIAS, CFG_DATA_W'(bias_on));
        cfg_write(CFG_BIAS_VALUE, CFG_DATA_W'(bias));
        settings_used++;
        in_burst_odds  = idle_on ? pick_burst_odds() : 0;
        out_burst_odds = idle_on ? pick_burst_odds() : 0;
    endtask

    // one setting: a few well-formed load/compute sequences plus some noise
    task automatic random_pass(input int in_cfg, input int out_cfg);
        int n_in;
        int n_out;
        set_layer(in_cfg, out_cfg, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  rand_q412());
        n_in  = (in_cfg > IN_USE_MAX) ? IN_USE_MAX : in_cfg;
        n_out = (out_cfg > OUT_MAX) ? OUT_MAX : out_cfg;
        repeat ($urandom_range(1, 3)) begin
            scatter_loads($urandom_range(0, 5));
            load_missing(n_in, n_out);
            if ($urandom_range(0, 5) == 0)
                queue_item(MODE_UNUSED, rand_index(), rand_index(), rand_q412());
            push_compute();
            if ($urandom_range(0, 4) == 0)
                push_compute();
        end
        // trailing loads with no compute behind them
        if ($urandom_range(0, 3) == 0)
            scatter_loads($urandom_range(1, 4));
    endtask

    initial begin : stimulus
        int in_cfg;
        int out_cfg;
        layer_cfg.in_count   = 7'd1;
        layer_cfg.out_count  = 7'd1;
        layer_cfg.act_mode   = 1'b0;
        layer_cfg.has_bias   = 1'b0;
        layer_cfg.bias_value = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme products, floor rounding, far corner indexes, unused mode
        set_layer(1, 1, 1'b0, 1'b0, 16'sd0);
        queue_item(OP_WR_ACT, 6'd0, 6'd0, -16'sd32768);
        queue_item(OP_WR_WEIGHT, 6'd0, 6'd0, -16'sd32768);
        push_compute();
        queue_item(OP_WR_WEIGHT, 6'd0, 6'd0, 16'sd32767);
        push_compute();
        queue_item(OP_WR_ACT, 6'd0, 6'd0, -16'sd1);
        queue_item(OP_WR_WEIGHT, 6'd0, 6'd0, 16'sd1);
        push_compute();
        queue_item(OP_WR_WEIGHT, 6'd63, 6'd63, 16'sd32767);
        queue_item(OP_WR_ACT, 6'd63, 6'd63, -16'sd32768);
        queue_item(MODE_UNUSED, 6'h3f, 6'h3f, -16'sd1);

        // no inputs in use: bias alone, under ReLU and linear
        set_layer(0, 2, 1'b1, 1'b1, -16'sd32768);
        push_compute();
        set_layer(0, 3, 1'b0, 1'b1, 16'sd32767);
        push_compute();

        // zero output neurons: a compute with no result
        set_layer(1, 0, 1'b1, 1'b0, 16'sd0);
        push_compute();

        // ReLU clamps a negative sum and passes a positive one
        set_layer(1, 1, 1'b1, 1'b0, 16'sd0);
        push_compute();
        queue_item(OP_WR_ACT, 6'd0, 6'd0, 16'sd32767);
        queue_item(OP_WR_WEIGHT, 6'd0, 6'd0, 16'sd32767);
        push_compute();

        // widest layers first: in_count above range, then out_count above range
        random_pass(127, 1);
        random_pass(1, 127);
        random_pass(64, 1);

        while (items_sent < ITEM_TARGET) begin
            if (items_sent > ITEM_TARGET - QUIET_TAIL)
                idle_on = 1'b0;
            case ($urandom_range(0, 11))
                0: begin
                    in_cfg  = 0;
                    out_cfg = $urandom_range(0, 64);
                end
                1: begin
                    in_cfg  = $urandom_range(9, 127);
                    out_cfg = $urandom_range(1, 2);
                end
                2: begin
                    in_cfg  = $urandom_range(0, 1);
                    out_cfg = $urandom_range(9, 127);
                end
                3: begin
                    in_cfg  = $urandom_range(1, 8);
                    out_cfg = 0;
                end
                default: begin
                    in_cfg  = $urandom_range(1, 8);
                    out_cfg = $urandom_range(1, 8);
                end
            endcase
            random_pass(in_cfg, out_cfg);
        end

        wait_drained();
        $display("Sent %0d load and compute transactions (%0d computes), checked %0d results.",
                 items_sent, computes_seen, results_checked);
        $display("Went through %0d layer settings: counts 0 to 127, linear and ReLU, bias on/off.",
                 settings_used);
        if (expected_neurons.size() != 0) begin
            $error("%0d expected results never arrived", expected_neurons.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("dense_layer_forward verification clean");
        end else begin
            $display("dense_layer_forward verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("dense_layer_forward verification failed");
        $finish;
    end

endmodule
`default_nettype wire
